// File: sv/fha_pkg.sv
// fha_pkg: command codes and fixed port widths for the flag handle allocator
// no dependencies; used by the top level and the port checker

package fha_pkg;

  localparam int CMD_W    = 3;
  localparam int HANDLE_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_SET    = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_TEST   = 3'd4
  } cmd_e;

endpackage

// File: sv/fha_ram.sv
// fha_ram: simple dual-port synchronous ram, one write and one registered read
// no dependencies; holds the flag store and the free stack

module fha_ram #(
  parameter int  DEPTH = 16,
  parameter int  WIDTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/flag_handle_allocator.sv
// flag_handle_allocator: handle allocator with lifo free stack and packed flag bits
// depends on fha_pkg and fha_ram
//
// one command word enters when start is high and busy is low. commands:
// create, delete, set flag, clear flag, test flag. each accepted word gives
// exactly one result word on handle_out_o, ok_o and flag_value_o, shown for
// one cycle with strobe high, registered after the command stage.
// a new command is taken every cycle while busy is low: the flag word and the
// stack entry are read at the accepting edge, modified and written back in the
// next cycle, with a one-entry bypass on each ram for a write that lands as the
// next command reads the same entry. throughput is set by the flag ram port:
// one read-modify-write per cycle.
// create fails (ok_o low, handle 0) once the fresh count reaches the top
// handle; otherwise it pops the free stack, else hands out a fresh handle.
// delete onto a full free stack drops the handle and reports ok_o low.
// after reset busy stays high for a clearing pass over the flag store, one
// word a cycle over 2^HANDLE_BITS / WORD_BITS words (rounded up), 8 by default.
// results cannot be held off; the receiver must take them as they come.

module flag_handle_allocator #(
  parameter int HANDLE_BITS = 8,
  parameter int WORD_BITS   = 32,
  parameter int FREE_DEPTH  = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic [fha_pkg::CMD_W-1:0]    command_i,
  input  logic [fha_pkg::HANDLE_W-1:0] handle_i,
  output logic                         busy,
  output logic                         strobe,
  output logic [fha_pkg::HANDLE_W-1:0] handle_out_o,
  output logic                         ok_o,
  output logic                         flag_value_o
);

  import fha_pkg::*;

  localparam int WORD_COUNT = (2**HANDLE_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int DIV_SH     = HANDLE_BITS + BIT_W;
  localparam int RECIP      = (2**DIV_SH + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W     = DIV_SH + HANDLE_BITS + 1;
  localparam int CALC_W     = HANDLE_BITS + BIT_W;
  localparam int SIDX_W     = $clog2(FREE_DEPTH);
  localparam int DEPTH_W    = $clog2(FREE_DEPTH + 1);
  localparam int EXT_W      = HANDLE_BITS + HANDLE_W;

  logic                   accept;
  logic [EXT_W-1:0]       handle_ext;
  logic [HANDLE_BITS-1:0] h_in;
  logic [PROD_W-1:0]      word_prod;
  logic [WIDX_W-1:0]      rd_word;

  // clearing pass
  logic              clr_busy_q, clr_busy_d;
  logic [WIDX_W-1:0] clr_addr_q, clr_addr_d;

  // command stage
  logic                   s1_valid_q;
  logic [CMD_W-1:0]       s1_cmd_q;
  logic [HANDLE_BITS-1:0] s1_h_q;
  logic [WIDX_W-1:0]      s1_word_q;

  // bypass of the last write on each ram
  logic                   fw_valid_q;
  logic [WIDX_W-1:0]      fw_addr_q;
  logic [WORD_BITS-1:0]   fw_word_q;
  logic                   sfw_valid_q;
  logic [SIDX_W-1:0]      sfw_addr_q;
  logic [HANDLE_BITS-1:0] sfw_data_q;

  logic [HANDLE_BITS-1:0] fresh_q, fresh_d;
  logic [DEPTH_W-1:0]     depth_q, depth_d;

  logic                   strobe_q;
  logic [HANDLE_W-1:0]    hout_q;
  logic                   ok_q;
  logic                   flag_q;

  // ram ports
  logic                   fmem_we;
  logic [WIDX_W-1:0]      fmem_waddr;
  logic [WORD_BITS-1:0]   fmem_wdata;
  logic [WORD_BITS-1:0]   fmem_rdata;
  logic [SIDX_W-1:0]      smem_raddr;
  logic [HANDLE_BITS-1:0] smem_rdata;

  // stage logic
  logic [CALC_W-1:0]      bit_base, bit_off;
  logic [WORD_BITS-1:0]   bit_mask;
  logic [WORD_BITS-1:0]   cur_word, new_word;
  logic [DEPTH_W-1:0]     depth_m1, depth_d_m1;
  logic [SIDX_W-1:0]      pop_idx, push_idx;
  logic [HANDLE_BITS-1:0] pop_val;
  logic                   flag_we, push_we;
  logic [HANDLE_BITS-1:0] hout;
  logic [EXT_W-1:0]       hout_ext;
  logic                   ok, flag;

  assign accept     = start & ~busy;
  assign handle_ext = EXT_W'(handle_i);
  assign h_in       = handle_ext[HANDLE_BITS-1:0];

  // word index by reciprocal multiply, exact for every handle
  assign word_prod = PROD_W'(h_in) * PROD_W'(RECIP);
  assign rd_word   = word_prod[DIV_SH +: WIDX_W];

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == WIDX_W'(WORD_COUNT - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  assign bit_base = CALC_W'(s1_word_q) * CALC_W'(WORD_BITS);
  assign bit_off  = CALC_W'(s1_h_q) - bit_base;
  assign bit_mask = WORD_BITS'(1) << bit_off[BIT_W-1:0];
  assign cur_word = (fw_valid_q && fw_addr_q == s1_word_q) ? fw_word_q : fmem_rdata;

  assign depth_m1 = depth_q - 1'b1;
  assign pop_idx  = depth_m1[SIDX_W-1:0];
  assign push_idx = depth_q[SIDX_W-1:0];
  assign pop_val  = (sfw_valid_q && sfw_addr_q == pop_idx) ? sfw_data_q : smem_rdata;

  always_comb begin
    fresh_d  = fresh_q;
    depth_d  = depth_q;
    flag_we  = 1'b0;
    push_we  = 1'b0;
    new_word = cur_word;
    hout     = s1_h_q;
    ok       = 1'b1;
    flag     = 1'b0;
    if (s1_valid_q) begin
      case (cmd_e'(s1_cmd_q))
        CMD_CREATE: begin
          if (fresh_q == '1) begin
            ok   = 1'b0;
            hout = '0;
          end else if (depth_q != '0) begin
            depth_d = depth_m1;
            hout    = pop_val;
          end else begin
            hout    = fresh_q;
            fresh_d = fresh_q + 1'b1;
          end
        end
        CMD_DELETE: begin
          if (depth_q < DEPTH_W'(FREE_DEPTH)) begin
            push_we = 1'b1;
            depth_d = depth_q + 1'b1;
          end else begin
            ok = 1'b0;
          end
          flag_we  = 1'b1;
          new_word = cur_word & ~bit_mask;
        end
        CMD_SET: begin
          flag_we  = 1'b1;
          new_word = cur_word | bit_mask;
        end
        CMD_CLEAR: begin
          flag_we  = 1'b1;
          new_word = cur_word & ~bit_mask;
        end
        CMD_TEST: begin
          flag = |(cur_word & bit_mask);
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  assign hout_ext = EXT_W'(hout);

  // next pop address follows the stack depth left by the command in flight
  assign depth_d_m1 = depth_d - 1'b1;
  assign smem_raddr = depth_d_m1[SIDX_W-1:0];

  assign fmem_we    = clr_busy_q | flag_we;
  assign fmem_waddr = clr_busy_q ? clr_addr_q : s1_word_q;
  assign fmem_wdata = clr_busy_q ? '0 : new_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      fw_valid_q  <= 1'b0;
      sfw_valid_q <= 1'b0;
      fresh_q     <= '0;
      depth_q     <= '0;
      strobe_q    <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      s1_valid_q  <= accept;
      fw_valid_q  <= flag_we;
      sfw_valid_q <= push_we;
      fresh_q     <= fresh_d;
      depth_q     <= depth_d;
      strobe_q    <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q   <= command_i;
    s1_h_q     <= h_in;
    s1_word_q  <= rd_word;
    fw_addr_q  <= s1_word_q;
    fw_word_q  <= new_word;
    sfw_addr_q <= push_idx;
    sfw_data_q <= s1_h_q;
    hout_q     <= hout_ext[HANDLE_W-1:0];
    ok_q       <= ok;
    flag_q     <= flag;
  end

  fha_ram #(
    .DEPTH (WORD_COUNT),
    .WIDTH (WORD_BITS)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (fmem_we),
    .waddr_i (fmem_waddr),
    .wdata_i (fmem_wdata),
    .raddr_i (rd_word),
    .rdata_o (fmem_rdata)
  );

  fha_ram #(
    .DEPTH (FREE_DEPTH),
    .WIDTH (HANDLE_BITS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (push_we),
    .waddr_i (push_idx),
    .wdata_i (s1_h_q),
    .raddr_i (smem_raddr),
    .rdata_o (smem_rdata)
  );

  assign busy         = clr_busy_q;
  assign strobe       = strobe_q;
  assign handle_out_o = hout_q;
  assign ok_o         = ok_q;
  assign flag_value_o = flag_q;

endmodule

// File: sv/fha_checker.sv
// fha_checker: port-level checks on the flag handle allocator, bound to the top level
// depends on fha_pkg

module fha_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic [fha_pkg::CMD_W-1:0]    command_i,
  input logic [fha_pkg::HANDLE_W-1:0] handle_i,
  input logic                         busy,
  input logic                         strobe,
  input logic [fha_pkg::HANDLE_W-1:0] handle_out_o,
  input logic                         ok_o,
  input logic                         flag_value_o
);

  import fha_pkg::*;

  // every accepted word gives a result word on strobe
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 strobe)
    else $error("no result word after accepted command");

  // no result word without an accepted command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> $past(start && !busy, 2))
    else $error("result word without command");

  // busy only during the clearing pass after reset
  a_busy_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("busy rose after clearing pass");

  // a refused create reports handle zero
  a_create_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && !ok_o && $past(command_i == CMD_CREATE, 2)) |-> (handle_out_o == '0))
    else $error("failed create with nonzero handle");

  // flag bit only reported for test
  a_flag_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && flag_value_o) |-> $past(command_i == CMD_TEST, 2))
    else $error("flag value set for command other than test");

endmodule

bind flag_handle_allocator fha_checker u_fha_checker (.*);
